// ===== design/mvsa_pkg.sv =====
// Shared types and constants of the MIDI voice slot allocator.
package mvsa_pkg;

  localparam int SlotIdxW = 4;
  localparam int StatusW  = 8;
  localparam int NoteW    = 7;
  localparam int VelW     = 7;
  localparam int StampW   = 64;
  localparam int MaskW    = 16;

  // Upper nibble of the status byte; the channel nibble is dropped.
  localparam logic [3:0] CmdNoteOn  = 4'h9;
  localparam logic [3:0] CmdNoteOff = 4'h8;
  localparam logic [3:0] CmdControl = 4'hB;

  localparam logic [NoteW-1:0] CcAllNotesOff = 7'd123;
  localparam logic [NoteW-1:0] CcAllSoundOff = 7'd120;

  typedef enum logic [1:0] {
    ACT_IGNORE  = 2'd0,
    ACT_ASSIGN  = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_ALL_OFF = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              held;
    logic [NoteW-1:0]  note;
    logic [VelW-1:0]   vel;
    logic [StampW-1:0] stamp;
  } slot_t;

  typedef struct packed {
    logic                en;
    logic [SlotIdxW-1:0] idx;
    logic [NoteW-1:0]    note;
    logic [VelW-1:0]     vel;
    logic [StampW-1:0]   stamp;
  } slot_wr_t;

  typedef struct packed {
    logic                match;
    logic [SlotIdxW-1:0] match_idx;
    logic                free;
    logic [SlotIdxW-1:0] free_idx;
    logic [SlotIdxW-1:0] min_idx;
  } scan_res_t;

  typedef struct packed {
    action_e             action;
    logic [SlotIdxW-1:0] slot_index;
    logic                retriggered;
    logic                stolen;
    logic [NoteW-1:0]    stolen_note;
    logic [MaskW-1:0]    released_mask;
    logic [VelW-1:0]     velocity;
  } result_t;

endpackage

// ===== design/mvsa_if.sv =====
// Stream interfaces for MIDI message beats in and allocation result beats out.
interface mvsa_in_if
  import mvsa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status_byte;
  logic [NoteW-1:0]   data_one;
  logic [VelW-1:0]    data_two;

  modport source (output valid, output status_byte, output data_one, output data_two,
                  input ready);
  modport sink   (input valid, input status_byte, input data_one, input data_two,
                  output ready);
endinterface

interface mvsa_out_if
  import mvsa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [SlotIdxW-1:0] slot_index;
  logic                retriggered;
  logic                stolen;
  logic [NoteW-1:0]    stolen_note;
  logic [MaskW-1:0]    released_mask;
  logic [VelW-1:0]     velocity;

  modport source (output valid, output action, output slot_index, output retriggered,
                  output stolen, output stolen_note, output released_mask,
                  output velocity, input ready);
  modport sink   (input valid, input action, input slot_index, input retriggered,
                  input stolen, input stolen_note, input released_mask,
                  input velocity, output ready);
endinterface

// ===== design/mvsa_slot_table.sv =====
// Voice slot table: held flags, notes, velocities and age stamps.
module mvsa_slot_table
  import mvsa_pkg::*;
#(
  parameter int NUM_VOICES = 10,
  parameter int IdxW       = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IdxW-1:0]       rd_idx_i,
  output slot_t                 rd_o,
  input  slot_wr_t              wr_i,
  input  logic                  clr_one_i,
  input  logic                  clr_all_i,
  output logic [NUM_VOICES-1:0] held_o
);

  logic [NUM_VOICES-1:0] held_q;
  logic [NoteW-1:0]      note_q  [NUM_VOICES];
  logic [VelW-1:0]       vel_q   [NUM_VOICES];
  logic [StampW-1:0]     stamp_q [NUM_VOICES];

  logic [IdxW-1:0] wr_idx;
  assign wr_idx = wr_i.idx[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (clr_all_i) begin
      held_q <= '0;
    end else if (wr_i.en) begin
      held_q[wr_idx] <= 1'b1;
    end else if (clr_one_i) begin
      held_q[rd_idx_i] <= 1'b0;
    end
  end

  // Payload: only read behind a held flag, so no reset needed.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      note_q[wr_idx]  <= wr_i.note;
      vel_q[wr_idx]   <= wr_i.vel;
      stamp_q[wr_idx] <= wr_i.stamp;
    end
  end

  assign rd_o.held  = held_q[rd_idx_i];
  assign rd_o.note  = note_q[rd_idx_i];
  assign rd_o.vel   = vel_q[rd_idx_i];
  assign rd_o.stamp = stamp_q[rd_idx_i];
  assign held_o     = held_q;

endmodule

// ===== design/mvsa_scan_unit.sv =====
// Slot scan unit: one slot a step through a shared note and stamp comparator.
module mvsa_scan_unit
  import mvsa_pkg::*;
#(
  parameter int IdxW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             first_i,
  input  logic [IdxW-1:0]  idx_i,
  input  slot_t            slot_i,
  input  logic [NoteW-1:0] note_i,
  output scan_res_t        res_o
);

  logic                match_q, match_d;
  logic [SlotIdxW-1:0] match_idx_q, match_idx_d;
  logic                free_q, free_d;
  logic [SlotIdxW-1:0] free_idx_q, free_idx_d;
  logic [SlotIdxW-1:0] min_idx_q, min_idx_d;
  logic [StampW-1:0]   min_stamp_q, min_stamp_d;

  logic                match_prev, free_prev;
  logic [SlotIdxW-1:0] idx_ext;

  assign idx_ext    = SlotIdxW'(idx_i);
  assign match_prev = first_i ? 1'b0 : match_q;
  assign free_prev  = first_i ? 1'b0 : free_q;

  always_comb begin
    match_d     = match_prev;
    match_idx_d = match_idx_q;
    free_d      = free_prev;
    free_idx_d  = free_idx_q;
    min_idx_d   = min_idx_q;
    min_stamp_d = min_stamp_q;
    // keep the lowest slot for each pick; strict compare keeps ties on the lower one
    if (!match_prev && slot_i.held && slot_i.note == note_i) begin
      match_d     = 1'b1;
      match_idx_d = idx_ext;
    end
    if (!free_prev && !slot_i.held) begin
      free_d     = 1'b1;
      free_idx_d = idx_ext;
    end
    if (first_i || slot_i.stamp < min_stamp_q) begin
      min_idx_d   = idx_ext;
      min_stamp_d = slot_i.stamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (en_i) begin
      match_q <= match_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      match_idx_q <= match_idx_d;
      free_idx_q  <= free_idx_d;
      min_idx_q   <= min_idx_d;
      min_stamp_q <= min_stamp_d;
    end
  end

  assign res_o.match     = match_q;
  assign res_o.match_idx = match_idx_q;
  assign res_o.free      = free_q;
  assign res_o.free_idx  = free_idx_q;
  assign res_o.min_idx   = min_idx_q;

endmodule

// ===== design/midi_voice_slot_allocator_top.sv =====
// Ignored and all-notes-off beats pass from idle through the done state into the output
// register; note-off and note-on scan the table one slot per cycle, and only note-on
// goes through the shared scan comparator and then the apply state before done.
// Input is taken only in idle; a finished result waits in the output register.
// Reset (asynchronous, active low) clears all held flags, the note-on counter,
// the sequencer and the output valid.
module midi_voice_slot_allocator_top
  import mvsa_pkg::*;
#(
  parameter int NUM_VOICES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mvsa_in_if.sink     in_i,
  mvsa_out_if.source  out_o
);

  localparam int IdxW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_VOICES - 1);

  state_e              state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [NoteW-1:0]    note_q, note_d;
  logic [VelW-1:0]     vel_q, vel_d;
  action_e             op_q, op_d;
  result_t             res_q, res_d;
  logic [StampW-1:0]   counter_q, counter_d;
  result_t             out_q, out_d;
  logic                out_valid_q, out_valid_d;

  slot_t                 rd_slot;
  logic [IdxW-1:0]       rd_idx;
  slot_wr_t              wr;
  logic                  clr_one, clr_all;
  logic [NUM_VOICES-1:0] held;
  scan_res_t             scan;
  logic                  scan_en;
  logic [SlotIdxW-1:0]   sel_idx;
  logic [3:0]            cmd;
  action_e               op_dec;
  logic                  in_fire;
  logic [StampW-1:0]     counter_inc;

  mvsa_slot_table #(
    .NUM_VOICES(NUM_VOICES),
    .IdxW      (IdxW)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_slot),
    .wr_i     (wr),
    .clr_one_i(clr_one),
    .clr_all_i(clr_all),
    .held_o   (held)
  );

  mvsa_scan_unit #(
    .IdxW(IdxW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (scan_en),
    .first_i(idx_q == '0),
    .idx_i  (idx_q),
    .slot_i (rd_slot),
    .note_i (note_q),
    .res_o  (scan)
  );

  assign cmd     = in_i.status_byte[StatusW-1:StatusW-4];
  assign in_fire = in_i.valid && in_i.ready;

  always_comb begin
    if (cmd == CmdNoteOn && in_i.data_two != '0) begin
      op_dec = ACT_ASSIGN;
    end else if (cmd == CmdNoteOff || cmd == CmdNoteOn) begin
      op_dec = ACT_RELEASE;
    end else if (cmd == CmdControl &&
                 (in_i.data_one == CcAllNotesOff || in_i.data_one == CcAllSoundOff)) begin
      op_dec = ACT_ALL_OFF;
    end else begin
      op_dec = ACT_IGNORE;
    end
  end

  // Slot choice order: same note held, then first free, then oldest stamp.
  assign sel_idx     = scan.match ? scan.match_idx : (scan.free ? scan.free_idx : scan.min_idx);
  assign counter_inc = counter_q + StampW'(1);
  assign rd_idx      = (state_q == ST_APPLY) ? sel_idx[IdxW-1:0] : idx_q;
  assign in_i.ready  = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    note_d      = note_q;
    vel_d       = vel_q;
    op_d        = op_q;
    res_d       = res_q;
    counter_d   = counter_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    scan_en     = 1'b0;
    clr_one     = 1'b0;
    clr_all     = 1'b0;
    wr          = '0;

    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          note_d        = in_i.data_one;
          vel_d         = in_i.data_two;
          op_d          = op_dec;
          idx_d         = '0;
          res_d         = '0;
          res_d.action  = op_dec;
          if (op_dec == ACT_ALL_OFF) begin
            res_d.released_mask = MaskW'(held);
            clr_all             = 1'b1;
          end
          if (op_dec == ACT_ASSIGN || op_dec == ACT_RELEASE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (op_q == ACT_ASSIGN) begin
          scan_en = 1'b1;
        end else if (rd_slot.held && rd_slot.note == note_q) begin
          clr_one             = 1'b1;
          res_d.released_mask = res_q.released_mask | (MaskW'(1) << idx_q);
        end
        idx_d = idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          state_d = (op_q == ACT_ASSIGN) ? ST_APPLY : ST_DONE;
        end
      end
      ST_APPLY: begin
        wr.en             = 1'b1;
        wr.idx            = sel_idx;
        wr.note           = note_q;
        wr.vel            = vel_q;
        wr.stamp          = counter_inc;
        counter_d         = counter_inc;
        res_d.slot_index  = sel_idx;
        res_d.retriggered = scan.match;
        res_d.velocity    = vel_q;
        if (!scan.match && !scan.free) begin
          res_d.stolen      = 1'b1;
          res_d.stolen_note = rd_slot.note;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      op_q        <= ACT_IGNORE;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      op_q        <= op_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
    vel_q  <= vel_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.action        = out_q.action;
  assign out_o.slot_index    = out_q.slot_index;
  assign out_o.retriggered   = out_q.retriggered;
  assign out_o.stolen        = out_q.stolen;
  assign out_o.stolen_note   = out_q.stolen_note;
  assign out_o.released_mask = out_q.released_mask;
  assign out_o.velocity      = out_q.velocity;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("sequencer did not leave idle after an input beat");

  a_steal_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY && !scan.match && !scan.free) |-> (&held))
    else $error("slot stolen while a free slot exists");

  a_assign_no_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.action == ACT_ASSIGN) |-> out_o.released_mask == '0)
    else $error("assign beat carries a release mask");

  a_retrig_not_stolen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.retriggered) |-> !out_o.stolen)
    else $error("retrigger and steal flagged together");

endmodule

// ===== verif/midi_voice_slot_allocator_top_test.sv =====
// Self-checking testbench for the MIDI voice slot allocator: directed and random message beats.
`timescale 1ns / 100ps

module midi_voice_slot_allocator_top_test;
  import mvsa_pkg::*;

  localparam int NumVoices  = 10;
  localparam int HalfPeriod = 10;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 2 * NumVoices + 8;
  localparam int RandomMsgs = 950;

  logic clk_i;
  logic rst_ni;

  mvsa_in_if  msg_if ();
  mvsa_out_if alloc_if ();

  midi_voice_slot_allocator_top #(
    .NUM_VOICES(NumVoices)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (msg_if),
    .out_o (alloc_if)
  );

  // Shadow copy of the voice table.
  logic                voice_held  [NumVoices];
  logic [NoteW-1:0]    voice_note  [NumVoices];
  logic [VelW-1:0]     voice_vel   [NumVoices];
  logic [StampW-1:0]   voice_stamp [NumVoices];
  logic [StampW-1:0]   note_on_count;

  result_t predicted_allocs[$];
  int      fail_count;
  int      cycle_count;
  int      hold_cycles;
  bit      steady_flow;

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("midi_voice_slot_allocator_top regression: fail");
      $finish;
    end
  end

  // Result side: idle at random, hold off for a counted stretch on request, or stay ready in steady flow.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      alloc_if.ready <= 1'b0;
      hold_cycles--;
    end else if (steady_flow) begin
      alloc_if.ready <= 1'b1;
    end else begin
      alloc_if.ready <= ($urandom_range(0, 99) >= 10);
    end
  end

  task automatic note_failure(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic result_t predict_allocation(input logic [StatusW-1:0] st,
                                                 input logic [NoteW-1:0] d1,
                                                 input logic [VelW-1:0] d2);
    result_t           r;
    logic [3:0]        cmd;
    int                pick;
    int                i;
    bit                retrig;
    logic [StampW-1:0] oldest;
    r      = '0;
    cmd    = st[7:4];
    pick   = -1;
    retrig = 1'b0;
    if (cmd == CmdNoteOn && d2 != '0) begin
      for (i = 0; i < NumVoices; i++) begin
        if (pick < 0 && voice_held[i] && voice_note[i] == d1) begin
          pick   = i;
          retrig = 1'b1;
        end
      end
      for (i = 0; i < NumVoices; i++) begin
        if (pick < 0 && !voice_held[i]) pick = i;
      end
      if (pick < 0) begin
        // Every voice is busy: steal the lowest stamp, first index on a tie.
        pick   = 0;
        oldest = voice_stamp[0];
        for (i = 1; i < NumVoices; i++) begin
          if (voice_stamp[i] < oldest) begin
            oldest = voice_stamp[i];
            pick   = i;
          end
        end
        r.stolen      = 1'b1;
        r.stolen_note = voice_note[pick];
      end
      note_on_count     = note_on_count + 1;
      voice_held[pick]  = 1'b1;
      voice_note[pick]  = d1;
      voice_vel[pick]   = d2;
      voice_stamp[pick] = note_on_count;
      r.action          = ACT_ASSIGN;
      r.slot_index      = pick[SlotIdxW-1:0];
      r.retriggered     = retrig;
      r.velocity        = d2;
    end else if (cmd == CmdNoteOff || cmd == CmdNoteOn) begin
      for (i = 0; i < NumVoices; i++) begin
        if (voice_held[i] && voice_note[i] == d1) begin
          voice_held[i]      = 1'b0;
          r.released_mask[i] = 1'b1;
        end
      end
      r.action = ACT_RELEASE;
    end else if (cmd == CmdControl && (d1 == CcAllNotesOff || d1 == CcAllSoundOff)) begin
      for (i = 0; i < NumVoices; i++) begin
        r.released_mask[i] = voice_held[i];
        voice_held[i]      = 1'b0;
      end
      r.action = ACT_ALL_OFF;
    end
    return r;
  endfunction

  // Offer one message beat; entered and left at a falling edge.
  task automatic send_msg(input logic [StatusW-1:0] st, input logic [NoteW-1:0] d1,
                          input logic [VelW-1:0] d2);
    while (!steady_flow && $urandom_range(0, 99) < 10) begin
      msg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    msg_if.valid       <= 1'b1;
    msg_if.status_byte <= st;
    msg_if.data_one    <= d1;
    msg_if.data_two    <= d2;
    do @(posedge clk_i); while (msg_if.ready !== 1'b1);
    predicted_allocs.push_back(predict_allocation(st, d1, d2));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && alloc_if.valid === 1'b1 && alloc_if.ready === 1'b1) begin
      if (predicted_allocs.size() == 0) begin
        note_failure("result beat with no message pending");
      end else begin
        want = predicted_allocs.pop_front();
        if (alloc_if.action !== want.action)
          note_failure($sformatf("action %0d, want %0d", alloc_if.action, want.action));
        if (alloc_if.slot_index !== want.slot_index)
          note_failure($sformatf("slot_index %0d, want %0d", alloc_if.slot_index,
                                 want.slot_index));
        if (alloc_if.retriggered !== want.retriggered)
          note_failure($sformatf("retriggered %0b, want %0b", alloc_if.retriggered,
                                 want.retriggered));
        if (alloc_if.stolen !== want.stolen)
          note_failure($sformatf("stolen %0b, want %0b", alloc_if.stolen, want.stolen));
        if (alloc_if.stolen_note !== want.stolen_note)
          note_failure($sformatf("stolen_note %0d, want %0d", alloc_if.stolen_note,
                                 want.stolen_note));
        if (alloc_if.released_mask !== want.released_mask)
          note_failure($sformatf("released_mask %h, want %h", alloc_if.released_mask,
                                 want.released_mask));
        if (alloc_if.velocity !== want.velocity)
          note_failure($sformatf("velocity %0d, want %0d", alloc_if.velocity,
                                 want.velocity));
      end
    end
  end

  function automatic logic [NoteW-1:0] pick_note();
    // Mostly a narrow band so notes collide, retrigger and get stolen.
    if ($urandom_range(0, 3) == 0) return NoteW'($urandom_range(0, 127));
    return NoteW'(60 + $urandom_range(0, 15));
  endfunction

  function automatic logic [3:0] any_channel();
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic test_ignored_messages();
    send_msg(8'h00, 7'd0, 7'd0);
    send_msg(8'hFF, 7'd127, 7'd127);
    send_msg({CmdControl, 4'h5}, 7'd121, 7'd64);
    send_msg(8'hA3, 7'd60, 7'd100);
  endtask

  task automatic test_note_edges();
    send_msg({CmdNoteOn, 4'h0}, 7'd0, 7'd1);
    send_msg({CmdNoteOn, 4'hF}, 7'd127, 7'd127);
    send_msg({CmdNoteOn, 4'h3}, 7'd0, 7'd64);       // retrigger, new velocity
    send_msg({CmdNoteOn, 4'h7}, 7'd127, 7'd0);      // zero velocity acts as note-off
    send_msg({CmdNoteOff, 4'h2}, 7'd5, 7'd127);     // nothing to release
    send_msg({CmdNoteOff, 4'hF}, 7'd0, 7'd0);
  endtask

  task automatic test_voice_stealing();
    int n;
    send_msg({CmdControl, 4'h0}, CcAllNotesOff, 7'd0);
    for (n = 0; n < NumVoices + 2; n++) begin
      send_msg({CmdNoteOn, any_channel()}, NoteW'(10 + n), VelW'(20 + n));
    end
    send_msg({CmdControl, 4'hA}, CcAllSoundOff, 7'd127);
    send_msg({CmdControl, 4'h1}, CcAllNotesOff, 7'd0);  // nothing held, empty mask
  endtask

  task automatic test_output_backpressure();
    int n;
    hold_cycles = 400;
    for (n = 0; n < 12; n++) begin
      send_msg({CmdNoteOn, any_channel()}, pick_note(), VelW'($urandom_range(1, 127)));
    end
  endtask

  task automatic test_random_traffic();
    int n;
    int roll;
    logic [StatusW-1:0] st;
    logic [NoteW-1:0]   d1;
    logic [VelW-1:0]    d2;
    for (n = 0; n < RandomMsgs; n++) begin
      steady_flow = (n >= 400 && n < 600);
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        st = {CmdNoteOn, any_channel()};
        d1 = pick_note();
        d2 = VelW'($urandom_range(1, 127));
      end else if (roll < 80) begin
        d1 = pick_note();
        if ($urandom_range(0, 1) == 0) begin
          st = {CmdNoteOff, any_channel()};
          d2 = VelW'($urandom_range(0, 127));
        end else begin
          st = {CmdNoteOn, any_channel()};
          d2 = '0;
        end
      end else if (roll < 84) begin
        st = {CmdControl, any_channel()};
        d1 = ($urandom_range(0, 1) == 0) ? CcAllNotesOff : CcAllSoundOff;
        d2 = VelW'($urandom_range(0, 127));
      end else begin
        st = StatusW'($urandom_range(0, 255));
        d1 = NoteW'($urandom_range(0, 127));
        d2 = VelW'($urandom_range(0, 127));
      end
      send_msg(st, d1, d2);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    msg_if.valid       = 1'b0;
    msg_if.status_byte = '0;
    msg_if.data_one    = '0;
    msg_if.data_two    = '0;
    alloc_if.ready     = 1'b0;
    fail_count         = 0;
    cycle_count        = 0;
    hold_cycles        = 0;
    steady_flow        = 1'b0;
    note_on_count      = '0;
    for (int i = 0; i < NumVoices; i++) begin
      voice_held[i]  = 1'b0;
      voice_note[i]  = '0;
      voice_vel[i]   = '0;
      voice_stamp[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_ignored_messages();
    test_note_edges();
    test_voice_stealing();
    test_output_backpressure();
    test_random_traffic();

    msg_if.valid <= 1'b0;
    while (predicted_allocs.size() != 0) @(posedge clk_i);
    // Let any stray beat surface before the verdict.
    repeat (DrainWait) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("midi_voice_slot_allocator_top regression: pass");
    end else begin
      $display("midi_voice_slot_allocator_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mvsa_pkg.sv
design/mvsa_if.sv
design/mvsa_slot_table.sv
design/mvsa_scan_unit.sv
design/midi_voice_slot_allocator_top.sv
verif/midi_voice_slot_allocator_top_test.sv
